FILE: sv/plc_enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar code encoder package
// shared widths, defaults and the in-word butterfly helpers
// ----------------------------------------------------------------------------
package plc_enc_pkg;

	localparam int CODE_LENGTH_DEF = 1024;
	localparam int CHUNK_W         = 64;
	localparam int CHUNK_SH        = 6;
	localparam int POS_W           = 10;
	localparam int CIDX_W          = 4;
	localparam int S_DATA_W        = 16;
	localparam int M_DATA_W        = 72;

	typedef logic [CHUNK_W-1:0] chunk_t;

	// bits j with (j & h) == 0, h = 2**s
	function automatic chunk_t lower_mask(input logic [2:0] s);
		chunk_t m;
		m = '0;
		for (int j = 0; j < CHUNK_W; j++) begin
			if ((j & (1 << s)) == 0) begin
				m[j] = 1'b1;
			end
		end
		return m;
	endfunction

	// one in-word butterfly stage of span 2**s
	function automatic chunk_t word_stage(input chunk_t w, input logic [2:0] s);
		chunk_t r;
		r = w;
		case (s)
			3'd0:    r = w ^ ((w >> 1)  & lower_mask(3'd0));
			3'd1:    r = w ^ ((w >> 2)  & lower_mask(3'd1));
			3'd2:    r = w ^ ((w >> 4)  & lower_mask(3'd2));
			3'd3:    r = w ^ ((w >> 8)  & lower_mask(3'd3));
			3'd4:    r = w ^ ((w >> 16) & lower_mask(3'd4));
			3'd5:    r = w ^ ((w >> 32) & lower_mask(3'd5));
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/polar_code_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar code encoder core
// gathers information bits, runs the arikan butterfly, emits 64-bit chunks
// ----------------------------------------------------------------------------
// info bits: one beat per cycle while idle
// transform: log2(CODE_LENGTH) passes over the CODE_LENGTH/64 words, one word
//   a cycle through the shared xor stage of a rotating word line
// chunks leave through the output register after the last transform pass,
//   one chunk per cycle while m_tready is high; input not ready until the last chunk is taken
// arst_n clears the word store, the sequencer and the output valid flag
module polar_code_encoder_core
	import plc_enc_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // info_bit, bit_position[9:0], zero fill
	input  logic                s_tlast,  // word_end
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // code_chunk[63:0], chunk_index[3:0], zero fill
	output logic                m_tlast   // chunk_last
);

	localparam int CHUNKS = CODE_LENGTH / CHUNK_W;
	localparam int WIDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int STAGES = $clog2(CODE_LENGTH);
	localparam int STG_W  = $clog2(STAGES);
	localparam int CNT_W  = $clog2(CHUNKS + 1);
	localparam int LEN_W  = ((POS_W > STAGES) ? POS_W : STAGES) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_XFORM = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]        state_q;
	chunk_t            store_q [CHUNKS];
	logic [STG_W-1:0]  stage_q;
	logic [WIDX_W-1:0] word_q;
	logic [CNT_W-1:0]  emit_q;
	chunk_t            out_data_q;
	logic [CIDX_W-1:0] out_idx_q;
	logic              out_last_q;
	logic              out_valid_q;

	logic              info_bit;
	logic [POS_W-1:0]  bit_position;
	logic              in_beat;
	logic              pos_ok;
	logic              word_done;
	logic              emit_load;
	logic              emit_done;
	chunk_t            head_new;

	assign info_bit     = s_tdata[0];
	assign bit_position = s_tdata[POS_W:1];
	assign s_tready     = (state_q == ST_IDLE);
	assign in_beat      = s_tvalid && s_tready;
	assign pos_ok       = (LEN_W'(bit_position) < LEN_W'(CODE_LENGTH));
	assign word_done    = (word_q == WIDX_W'(CHUNKS - 1));
	assign emit_load    = (state_q == ST_EMIT) && (emit_q < CNT_W'(CHUNKS))
		&& (!out_valid_q || m_tready);
	assign emit_done    = (state_q == ST_EMIT) && (emit_q == CNT_W'(CHUNKS))
		&& (!out_valid_q || m_tready);

	// shared stage unit on the head word
	always_comb begin
		head_new = store_q[0];
		if (32'(stage_q) < CHUNK_SH) begin
			head_new = word_stage(store_q[0], 3'(stage_q));
		end else begin
			for (int j = 0; j < WIDX_W; j++) begin
				if ((1 << j) < CHUNKS && 32'(stage_q) == j + CHUNK_SH && !word_q[j]) begin
					head_new = store_q[0] ^ store_q[WIDX_W'((1 << j) % CHUNKS)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= '0;
			word_q  <= '0;
			emit_q  <= '0;
			for (int w = 0; w < CHUNKS; w++) begin
				store_q[w] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (pos_ok) begin
							for (int w = 0; w < CHUNKS; w++) begin
								if (32'(bit_position >> CHUNK_SH) == w) begin
									store_q[w][bit_position[CHUNK_SH-1:0]] <= info_bit;
								end
							end
						end
						if (s_tlast) begin
							state_q <= ST_XFORM;
							stage_q <= STG_W'(STAGES - 1);
							word_q  <= '0;
						end
					end
				end
				ST_XFORM: begin
					for (int w = 0; w < CHUNKS - 1; w++) begin
						store_q[w] <= store_q[w + 1];
					end
					store_q[CHUNKS - 1] <= head_new;
					if (word_done) begin
						word_q <= '0;
						if (stage_q == '0) begin
							state_q <= ST_EMIT;
							emit_q  <= '0;
						end else begin
							stage_q <= stage_q - 1'b1;
						end
					end else begin
						word_q <= word_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						for (int w = 0; w < CHUNKS - 1; w++) begin
							store_q[w] <= store_q[w + 1];
						end
						store_q[CHUNKS - 1] <= '0;
						emit_q <= emit_q + 1'b1;
					end
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= store_q[0];
			out_idx_q  <= CIDX_W'(emit_q);
			out_last_q <= (emit_q == CNT_W'(CHUNKS - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W - CHUNK_W - CIDX_W){1'b0}}, out_idx_q, out_data_q};
	assign m_tlast  = out_last_q;

	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("output beat pending while idle");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still ready after end beat");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("output not drained after last chunk");

endmodule

FILE: tb/polar_code_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar code encoder checker
// watches both stream channels, keeps its own copy of the bit store, runs the
// arikan kernel on every end beat and compares each output chunk in order
// ----------------------------------------------------------------------------
module polar_code_encoder_checker
	import plc_enc_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tlast,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic                m_tlast,
	output int                  fail_count,
	output int                  pending_chunks,
	output int                  chunks_seen
);

	localparam int CHUNKS = CODE_LENGTH / CHUNK_W;

	typedef struct {
		chunk_t              data;
		logic [CIDX_W-1:0]   idx;
		logic                last;
	} coded_chunk_t;

	logic [CODE_LENGTH-1:0] gathered_bits;
	logic [CODE_LENGTH-1:0] codeword;
	coded_chunk_t           chunks_due[$];
	coded_chunk_t           due;
	logic [POS_W-1:0]       beat_pos;
	chunk_t                 got_data;
	logic [CIDX_W-1:0]      got_idx;
	int                     errs;
	int                     seen;

	// natural-order kernel: lower half of each block takes the xor of its upper half
	function automatic logic [CODE_LENGTH-1:0] arikan_encode(input logic [CODE_LENGTH-1:0] u);
		logic [CODE_LENGTH-1:0] x;
		x = u;
		for (int h = CODE_LENGTH / 2; h >= 1; h = h / 2) begin
			for (int i = 0; i < CODE_LENGTH; i++) begin
				if ((i & h) == 0) begin
					x[i] = x[i] ^ x[i + h];
				end
			end
		end
		return x;
	endfunction

	task automatic note_error(input string what);
		errs++;
		$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gathered_bits = '0;
			chunks_due.delete();
			errs = 0;
			seen = 0;
			fail_count     <= 0;
			pending_chunks <= 0;
			chunks_seen    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen++;
				got_data = m_tdata[CHUNK_W-1:0];
				got_idx  = m_tdata[CHUNK_W +: CIDX_W];
				if (chunks_due.size() == 0) begin
					note_error($sformatf("unexpected chunk: expected none, got data %h idx %0d last %b",
						got_data, got_idx, m_tlast));
				end else begin
					due = chunks_due.pop_front();
					if (got_data !== due.data) begin
						note_error($sformatf("code_chunk mismatch: expected %h, got %h",
							due.data, got_data));
					end
					if (got_idx !== due.idx) begin
						note_error($sformatf("chunk_index mismatch: expected %0d, got %0d",
							due.idx, got_idx));
					end
					if (m_tlast !== due.last) begin
						note_error($sformatf("chunk_last mismatch: expected %b, got %b",
							due.last, m_tlast));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				beat_pos = s_tdata[POS_W:1];
				if (beat_pos < CODE_LENGTH) begin
					gathered_bits[beat_pos] = s_tdata[0];
				end
				if (s_tlast) begin
					codeword = arikan_encode(gathered_bits);
					for (int c = 0; c < CHUNKS; c++) begin
						due.data = codeword[c*CHUNK_W +: CHUNK_W];
						due.idx  = c[CIDX_W-1:0];
						due.last = (c == CHUNKS - 1);
						chunks_due.push_back(due);
					end
					gathered_bits = '0;
				end
			end
			fail_count     <= errs;
			pending_chunks <= chunks_due.size();
			chunks_seen    <= seen;
		end
	end

endmodule

FILE: tb/polar_code_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar code encoder core testbench
// directed words for single bits, overwrites and empty words, then
// random words under four idling profiles and one long output hold-off
// ----------------------------------------------------------------------------
module polar_code_encoder_core_tb;
	import plc_enc_pkg::*;

	localparam int CODE_LENGTH = CODE_LENGTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BEATS = 52;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	int fail_count;
	int pending_chunks;
	int chunks_seen;
	int gap_pct;
	int stall_pct;
	bit hold_req;
	bit hold_issued;
	int quiet_cycles;
	int words_sent;
	int directed_beats;
	int random_beats;

	polar_code_encoder_core #(
		.CODE_LENGTH(CODE_LENGTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	polar_code_encoder_checker #(
		.CODE_LENGTH(CODE_LENGTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending_chunks(pending_chunks),
		.chunks_seen(chunks_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one info beat, with random gaps ahead of it
	task automatic send_bit(input logic b, input logic [POS_W-1:0] p, input logic e);
		logic [S_DATA_W-1:0] beat;
		beat = '0;
		beat[0] = b;
		beat[POS_W:1] = p;
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		s_tlast  <= e;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (e) begin
			words_sent++;
		end
	endtask

	task automatic send_random_word(input int len);
		logic [POS_W-1:0] p;
		for (int k = 0; k < len; k++) begin
			if (k == 0 || $urandom_range(99) >= 15) begin
				p = POS_W'($urandom_range(2**POS_W - 1));
			end
			send_bit(1'($urandom_range(1)), p, k == len - 1);
			random_beats++;
		end
	endtask

	// output side
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d cycles with no beat", quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int phase_start;
		int beats_left;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		gap_pct      = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		hold_issued  = 1'b0;
		quiet_cycles = 0;
		words_sent   = 0;
		random_beats = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single bit at the lowest index, alone in its word
		send_bit(1'b1, '0, 1'b1);
		// single bit at the highest index
		send_bit(1'b1, '1, 1'b1);
		// nothing set: all frozen
		send_bit(1'b0, '0, 1'b1);
		// overwrite of one position, end beat carries a zero
		send_bit(1'b1, 10'd500, 1'b0);
		send_bit(1'b0, 10'd500, 1'b0);
		send_bit(1'b1, 10'd500, 1'b0);
		send_bit(1'b0, 10'd7, 1'b1);
		// half boundaries and extremes together
		send_bit(1'b1, 10'd511, 1'b0);
		send_bit(1'b1, 10'd512, 1'b0);
		send_bit(1'b1, 10'd1, 1'b0);
		send_bit(1'b1, 10'd1022, 1'b0);
		send_bit(1'b0, '1, 1'b0);
		send_bit(1'b1, '0, 1'b1);
		// a set bit cleared again by the end beat
		send_bit(1'b1, 10'd63, 1'b0);
		send_bit(1'b1, 10'd64, 1'b0);
		send_bit(1'b0, 10'd63, 1'b1);
		directed_beats = 16;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 62; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 62; end
				default: begin gap_pct = 23; stall_pct = 23; end
			endcase
			phase_start = random_beats;
			while (random_beats - phase_start < PHASE_BEATS) begin
				if (ph == 0 && random_beats - phase_start >= 8 && !hold_issued) begin
					hold_req    = 1'b1;
					hold_issued = 1'b1;
				end
				beats_left = PHASE_BEATS - (random_beats - phase_start);
				send_random_word($urandom_range(1, (beats_left < 24) ? beats_left : 24));
			end
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (pending_chunks != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d words: %0d directed and %0d random beats over four idle profiles",
			words_sent, directed_beats, random_beats);
		$display("%0d chunks compared, %0d failures", chunks_seen, fail_count);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/plc_enc_pkg.sv
sv/polar_code_encoder_core.sv
tb/polar_code_encoder_checker.sv
tb/polar_code_encoder_core_tb.sv
